@@ sv/advert_aes_ctr_decrypt_macros.svh @@
// Assertion macros for the advertisement frame decryptor.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ADVERT_AES_CTR_DECRYPT_MACROS_SVH
`define ADVERT_AES_CTR_DECRYPT_MACROS_SVH
`ifndef SYNTHESIS
`define AAD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AAD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define AAD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ sv/aad_pkg.sv @@
// Package for the advertisement frame decryptor: state enums, status codes,
// AES S-box and helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aad_pkg;

    localparam logic [7:0] COMPANY_LO = 8'hE1;
    localparam logic [7:0] COMPANY_HI = 8'h02;
    localparam int         HEADER_LEN = 10;
    localparam int         MIN_LEN    = 11;
    localparam int         RESULT_CAP = 16;
    localparam logic [6:0] COUNT_MAX  = 7'd127;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_COMPANY   = 3'd2,
        ST_KEY_CHECK = 3'd3,
        ST_LONG      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_RECV,
        S_CHECK,
        S_AES,
        S_EMIT,
        S_ERROR
    } t_state;

    // Control between sequencer and round unit
    typedef struct packed {
        logic start;
    } t_aes_ctl;

    typedef struct packed {
        logic done;
    } t_aes_sts;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
        8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
        8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
        8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
        8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
        8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
        8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
        8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
        8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
        8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
        8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
        8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
        8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
        8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
        8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
        8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
        8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
        8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
        8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
        8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
        8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
        8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
        8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
        8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
        8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
        8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
        8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
        8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
        8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
        8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
        8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
        8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
        8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
        8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
        8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
        8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
        8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
        8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
        8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
        8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
        8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
        8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
        8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
        8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
        8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
        8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
        8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
        8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
        8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
        8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
        8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
        8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
        8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
        8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
        8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
        8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
        8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
        8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
        8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
        8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
        8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
        8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
        8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
        8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
        8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

@@ sv/aad_aes_round.sv @@
// Iterative AES-128 encrypt: one round per cycle, round key expanded on the fly.
// Depends on aad_pkg (sbox, xt, control structs).
`timescale 1ns / 1ps
`default_nettype none
`include "advert_aes_ctr_decrypt_macros.svh"
module aad_aes_round (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire aad_pkg::t_aes_ctl i_ctl,
    input  wire logic [127:0]     i_key,
    input  wire logic [127:0]     i_block,
    output aad_pkg::t_aes_sts     o_sts,
    output logic [127:0]          o_block
);
    logic [127:0] r_state, n_state;
    logic [127:0] r_rk, n_rk;
    logic [3:0]   r_round, n_round;
    logic [7:0]   r_rcon, n_rcon;
    logic         r_busy, n_busy;
    logic         r_done, n_done;

    // byte i of a 128-bit word at bits 8i+7:8i
    logic [127:0] w_sub, w_mix, w_next_rk;
    logic [31:0]  w_rot;

    always_comb begin
        // key schedule step from current round key
        w_rot = {aad_pkg::sbox(r_rk[103:96]), aad_pkg::sbox(r_rk[127:120]),
                 aad_pkg::sbox(r_rk[119:112]), aad_pkg::sbox(r_rk[111:104]) ^ r_rcon};
        w_next_rk[31:0]   = r_rk[31:0]   ^ w_rot;
        w_next_rk[63:32]  = r_rk[63:32]  ^ w_next_rk[31:0];
        w_next_rk[95:64]  = r_rk[95:64]  ^ w_next_rk[63:32];
        w_next_rk[127:96] = r_rk[127:96] ^ w_next_rk[95:64];
        // sub bytes with shift rows
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_sub[(c*4+i)*8 +: 8] = aad_pkg::sbox(r_state[(((c+i)%4)*4+i)*8 +: 8]);
            end
        end
        // mix columns
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = w_sub[(c*4)*8 +: 8];
            a1 = w_sub[(c*4+1)*8 +: 8];
            a2 = w_sub[(c*4+2)*8 +: 8];
            a3 = w_sub[(c*4+3)*8 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            w_mix[(c*4)*8 +: 8]   = a0 ^ al ^ aad_pkg::xt(a0 ^ a1);
            w_mix[(c*4+1)*8 +: 8] = a1 ^ al ^ aad_pkg::xt(a1 ^ a2);
            w_mix[(c*4+2)*8 +: 8] = a2 ^ al ^ aad_pkg::xt(a2 ^ a3);
            w_mix[(c*4+3)*8 +: 8] = a3 ^ al ^ aad_pkg::xt(a3 ^ a0);
        end
    end

    // round sequencer
    always_comb begin
        n_state = r_state;
        n_rk    = r_rk;
        n_round = r_round;
        n_rcon  = r_rcon;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_ctl.start) begin
            n_state = i_block ^ i_key;
            n_rk    = i_key;
            n_round = 4'd1;
            n_rcon  = 8'h01;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_state = ((r_round == 4'd10) ? w_sub : w_mix) ^ w_next_rk;
            n_rk    = w_next_rk;
            n_rcon  = aad_pkg::xt(r_rcon);
            n_round = r_round + 4'd1;
            if (r_round == 4'd10) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rk    <= n_rk;
        r_round <= n_round;
        r_rcon  <= n_rcon;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_sts.done = r_done;
    assign o_block    = r_state;

    `AAD_ASSERT_NEXT(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
    `AAD_ASSERT_IMPL(a_round_range, i_clk, i_rst_n,
        !r_busy || (r_round >= 4'd1 && r_round <= 4'd10), "round out of range")
    `AAD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_ctl.start, r_busy, "start did not launch")
endmodule
`default_nettype wire

@@ sv/advert_aes_ctr_decrypt.sv @@
// Advertisement frame decryptor (AES-128 CTR). Frame bytes are taken one per
// beat until the final byte; no result leaves before the frame closes. The
// frame is then checked and, if it passes, one 16-byte keystream block is
// computed by the iterative round unit, after which plaintext bytes are
// offered one per cycle while the result side is ready. No new frame byte is
// taken until the last result of a frame (or its error result) is accepted.
// Depends on aad_pkg and aad_aes_round.
`timescale 1ns / 1ps
`default_nettype none
`include "advert_aes_ctr_decrypt_macros.svh"
module advert_aes_ctr_decrypt #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_final_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_plain_byte,
    output logic [2:0]       o_status,
    output logic             o_run_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    localparam int CW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LIM = (MAX_PAYLOAD < aad_pkg::RESULT_CAP) ? MAX_PAYLOAD
                                                              : aad_pkg::RESULT_CAP;
    localparam logic [1:0] REG_KEY_LO = 2'd0;
    localparam logic [1:0] REG_KEY_HI = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    // configuration registers
    logic [63:0] r_key_lo, r_key_hi;
    logic [4:0]  r_limit;
    logic        w_wr;
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_limit  <= 5'd16;
        end else if (w_wr && paddr[2:0] == 3'd0 && paddr[4:3] == REG_KEY_LO) begin
            r_key_lo <= pwdata;
        end else if (w_wr && paddr[2:0] == 3'd0 && paddr[4:3] == REG_KEY_HI) begin
            r_key_hi <= pwdata;
        end else if (w_wr && paddr[2:0] == 3'd0 && paddr[4:3] == REG_LIMIT) begin
            r_limit <= pwdata[4:0];
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_KEY_LO: prdata = r_key_lo;
            REG_KEY_HI: prdata = r_key_hi;
            REG_LIMIT:  prdata = {59'd0, r_limit};
            default:    prdata = '0;
        endcase
    end

    // frame stores
    logic [7:0] r_hdr [aad_pkg::HEADER_LEN];
    logic [7:0] r_ct  [MAX_PAYLOAD];
    logic [6:0] r_count, n_count;
    logic [6:0] r_len, n_len;
    logic [4:0] r_idx, n_idx;
    logic [4:0] r_ctlen, n_ctlen;
    aad_pkg::t_state r_st, n_st;
    logic [2:0] r_code, n_code;
    logic [7:0] r_ct_rd;

    aad_pkg::t_aes_ctl w_ctl;
    aad_pkg::t_aes_sts w_sts;
    logic [127:0] w_ks, w_ctr;

    assign w_ctr = {111'd0, 1'b0, r_hdr[8], r_hdr[7]};

    aad_aes_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   ({r_key_hi, r_key_lo}),
        .i_block (w_ctr),
        .o_sts   (w_sts),
        .o_block (w_ks)
    );

    logic w_in_acc, w_out_acc;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (r_count < 7'(aad_pkg::HEADER_LEN)) begin
                r_hdr[r_count[3:0]] <= i_frame_byte;
            end else if (r_count < 7'(aad_pkg::HEADER_LEN + MAX_PAYLOAD)) begin
                r_ct[CW'(r_count - 7'(aad_pkg::HEADER_LEN))] <= i_frame_byte;
            end
        end
        r_ct_rd <= r_ct[CW'(n_idx)];
    end

    // sequencer
    always_comb begin
        n_st    = r_st;
        n_count = r_count;
        n_len   = r_len;
        n_idx   = r_idx;
        n_ctlen = r_ctlen;
        n_code  = r_code;
        w_ctl.start = 1'b0;
        o_ready = 1'b0;
        unique case (r_st)
            aad_pkg::S_RECV: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_len = (r_count < aad_pkg::COUNT_MAX) ? r_count + 7'd1 : r_count;
                    n_count = n_len;
                    if (i_final_byte) begin
                        n_count = '0;
                        n_st = aad_pkg::S_CHECK;
                    end
                end
            end
            aad_pkg::S_CHECK: begin
                n_idx = '0;
                n_st  = aad_pkg::S_ERROR;
                if (r_len < 7'(aad_pkg::MIN_LEN)) begin
                    n_code = aad_pkg::ST_SHORT;
                end else if (r_hdr[0] != aad_pkg::COMPANY_LO
                             || r_hdr[1] != aad_pkg::COMPANY_HI) begin
                    n_code = aad_pkg::ST_COMPANY;
                end else if (r_hdr[9] != r_key_lo[7:0]) begin
                    n_code = aad_pkg::ST_KEY_CHECK;
                end else if (r_len - 7'(aad_pkg::HEADER_LEN) > 7'(r_limit)
                             || r_len - 7'(aad_pkg::HEADER_LEN) > 7'(LIM)) begin
                    n_code = aad_pkg::ST_LONG;
                end else begin
                    n_code  = aad_pkg::ST_OK;
                    n_ctlen = 5'(r_len - 7'(aad_pkg::HEADER_LEN));
                    w_ctl.start = 1'b1;
                    n_st = aad_pkg::S_AES;
                end
            end
            aad_pkg::S_AES: begin
                if (w_sts.done) n_st = aad_pkg::S_EMIT;
            end
            aad_pkg::S_EMIT: begin
                if (i_ready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_ctlen) n_st = aad_pkg::S_RECV;
                end
            end
            aad_pkg::S_ERROR: begin
                if (i_ready) n_st = aad_pkg::S_RECV;
            end
            default: n_st = aad_pkg::S_RECV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_ctlen <= n_ctlen;
        r_code  <= n_code;
        r_idx   <= n_idx;
        if (!i_rst_n) begin
            r_st    <= aad_pkg::S_RECV;
            r_count <= '0;
        end else begin
            r_st    <= n_st;
            r_count <= n_count;
        end
    end

    // result beat
    assign o_valid      = (r_st == aad_pkg::S_EMIT) || (r_st == aad_pkg::S_ERROR);
    assign o_plain_byte = (r_st == aad_pkg::S_EMIT)
                          ? (r_ct_rd ^ w_ks[{r_idx[3:0], 3'b000} +: 8]) : 8'd0;
    assign o_status     = r_code;
    assign o_run_end    = (r_st == aad_pkg::S_ERROR) || (r_idx + 1'b1 == r_ctlen);

    `AAD_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, !(o_ready && o_valid),
        "ready while emitting")
    `AAD_ASSERT_NEXT(a_err_once, i_clk, i_rst_n, w_out_acc && r_st == aad_pkg::S_ERROR,
        o_ready, "error result repeated")
    `AAD_ASSERT_IMPL(a_emit_idx, i_clk, i_rst_n, r_st != aad_pkg::S_EMIT || r_idx < r_ctlen,
        "emit index past length")
    `AAD_ASSERT_IMPL(a_ok_code, i_clk, i_rst_n,
        r_st != aad_pkg::S_EMIT || r_code == aad_pkg::ST_OK, "emit with error code")
    `AAD_ASSERT_NEXT(a_accept_final, i_clk, i_rst_n, w_in_acc && i_final_byte,
        r_st == aad_pkg::S_CHECK, "final byte missed")
endmodule
`default_nettype wire

@@ sim/tb_advert_aes_ctr_decrypt.sv @@
// Testbench for the advertisement frame decryptor (AES-128 CTR).
// Predicts each frame's results with a behavioral AES and compares them beat by beat.
// Depends on aad_pkg and the advert_aes_ctr_decrypt RTL.
`timescale 1ns / 1ps
module tb_advert_aes_ctr_decrypt;

    localparam int ADDR_KEY_LO = 0;
    localparam int ADDR_KEY_HI = 8;
    localparam int ADDR_LIMIT  = 16;
    localparam int MAX_PL      = 16;
    localparam int WATCHDOG    = 20000;

    typedef struct packed {
        logic [7:0]       plain;
        aad_pkg::t_status status;
        logic             last;
    } t_plain_beat;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  frame_byte = 0;
    logic        final_byte = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [7:0]  plain_byte;
    logic [2:0]  status;
    logic        run_end;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;

    advert_aes_ctr_decrypt i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_frame_byte(frame_byte), .i_final_byte(final_byte),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_plain_byte(plain_byte), .o_status(status), .o_run_end(run_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // predictor state
    logic [63:0] key_lo = 0, key_hi = 0;
    logic [4:0]  limit_reg = 5'd16;
    logic [7:0]  hdr_bytes [10];
    logic [7:0]  ct_bytes [MAX_PL];
    int          rx_count = 0;
    t_plain_beat expected_beats [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          out_wait = 0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc, x;
        acc = 0;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] s_of(input logic [7:0] a);
        logic [7:0] p, q, r;
        p = a;
        // inverse in GF(2^8) via a^254, then affine map
        q = 8'h01;
        for (int k = 0; k < 254; k++) q = gmul(q, p);
        if (a == 0) q = 0;
        r = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
        return r ^ 8'h63;
    endfunction

    logic [7:0] sub_tab [256];
    initial for (int k = 0; k < 256; k++) sub_tab[k] = s_of(k[7:0]);

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic keystream(input logic [7:0] key [16], input logic [7:0] blk [16],
                             output logic [7:0] ks [16]);
        logic [7:0] rk [176];
        logic [7:0] st [16], tt [16], w [4], hold, a0, a1, a2, a3, all, rc;
        rc = 8'h01;
        for (int k = 0; k < 16; k++) rk[k] = key[k];
        for (int i = 4; i < 44; i++) begin
            for (int c = 0; c < 4; c++) w[c] = rk[(i - 1) * 4 + c];
            if (i % 4 == 0) begin
                hold = w[0];
                w[0] = sub_tab[w[1]] ^ rc;
                w[1] = sub_tab[w[2]];
                w[2] = sub_tab[w[3]];
                w[3] = sub_tab[hold];
                rc = dbl(rc);
            end
            for (int c = 0; c < 4; c++) rk[i * 4 + c] = rk[(i - 4) * 4 + c] ^ w[c];
        end
        for (int k = 0; k < 16; k++) st[k] = blk[k] ^ rk[k];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) tt[c * 4 + i] = sub_tab[st[((c + i) % 4) * 4 + i]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tt[c*4]; a1 = tt[c*4+1]; a2 = tt[c*4+2]; a3 = tt[c*4+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    tt[c*4]   = a0 ^ all ^ dbl(a0 ^ a1);
                    tt[c*4+1] = a1 ^ all ^ dbl(a1 ^ a2);
                    tt[c*4+2] = a2 ^ all ^ dbl(a2 ^ a3);
                    tt[c*4+3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            for (int k = 0; k < 16; k++) st[k] = tt[k] ^ rk[r * 16 + k];
        end
        ks = st;
    endtask

    task automatic push_error(input aad_pkg::t_status code);
        t_plain_beat b;
        b.plain = 0;
        b.status = code;
        b.last = 1;
        expected_beats.push_back(b);
    endtask

    // model one accepted frame byte
    task automatic predict_byte(input logic [7:0] data, input logic fin);
        logic [7:0] key [16], blk [16], ks [16];
        t_plain_beat b;
        int flen, ct_len, lim;
        if (rx_count < 10) hdr_bytes[rx_count] = data;
        else if (rx_count < 10 + MAX_PL) ct_bytes[rx_count - 10] = data;
        if (rx_count < 127) rx_count++;
        if (!fin) return;
        flen = rx_count;
        rx_count = 0;
        for (int k = 0; k < 8; k++) begin
            key[k] = key_lo[8*k +: 8];
            key[k + 8] = key_hi[8*k +: 8];
        end
        lim = limit_reg;
        if (lim > MAX_PL) lim = MAX_PL;
        if (flen < aad_pkg::MIN_LEN) push_error(aad_pkg::ST_SHORT);
        else if (hdr_bytes[0] != aad_pkg::COMPANY_LO || hdr_bytes[1] != aad_pkg::COMPANY_HI)
            push_error(aad_pkg::ST_COMPANY);
        else if (hdr_bytes[9] != key[0]) push_error(aad_pkg::ST_KEY_CHECK);
        else if (flen - 10 > lim) push_error(aad_pkg::ST_LONG);
        else begin
            ct_len = flen - 10;
            for (int k = 0; k < 16; k++) blk[k] = 0;
            blk[0] = hdr_bytes[7];
            blk[1] = hdr_bytes[8];
            keystream(key, blk, ks);
            for (int i = 0; i < ct_len; i++) begin
                b.plain = ct_bytes[i] ^ ks[i];
                b.status = aad_pkg::ST_OK;
                b.last = (i + 1 == ct_len);
                expected_beats.push_back(b);
            end
        end
    endtask

    // APB write: setup then access
    task automatic reg_write(input int addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr[4:0]; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_KEY_LO) key_lo = value;
        else if (addr == ADDR_KEY_HI) key_hi = value;
        else limit_reg = value[4:0];
    endtask

    // valid stays up after a beat; it drops only for an idle gap or a drain
    task automatic send_byte(input logic [7:0] data, input logic fin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; frame_byte <= data; final_byte <= fin;
        do @(posedge clk); while (!in_ready);
        predict_byte(data, fin);
    endtask

    // wait for the block to drain before touching registers
    task automatic wait_drained();
        in_valid <= 0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // frame with good header unless corrupted; ct_len ciphertext bytes
    task automatic send_frame(input int ct_len, input bit good_co, input bit good_key);
        logic [7:0] h;
        for (int i = 0; i < 10 + ct_len; i++) begin
            h = 8'($urandom);
            if (i == 0)
                h = good_co ? aad_pkg::COMPANY_LO : ($urandom_range(0, 1) ? 8'hE0 : h);
            if (i == 1) h = good_co ? aad_pkg::COMPANY_HI : 8'h03;
            if (i == 9) h = good_key ? key_lo[7:0] : key_lo[7:0] ^ (8'h1 << $urandom_range(0, 7));
            send_byte(h, i == 9 + ct_len);
        end
    endtask

    task automatic send_raw(input int flen);
        for (int i = 0; i < flen; i++) send_byte(8'($urandom), i == flen - 1);
    endtask

    // output stall and compare
    always @(posedge clk) begin
        t_plain_beat exp_b;
        int out_draw;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h %0d %b",
                        plain_byte, status, run_end);
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (exp_b.plain !== plain_byte || exp_b.status !== status ||
                        exp_b.last !== run_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h/%0d/%b got %h/%0d/%b", exp_b.plain,
                                exp_b.status, exp_b.last, plain_byte, status, run_end);
                    end
                end
                // wait drawn for the next result
                out_draw = $urandom_range(0, 16);
                if (out_draw != 0) begin
                    out_ready <= 1'b0;
                    out_wait  <= out_draw - 1;
                end
            end else if (out_wait > 0) begin
                out_wait <= out_wait - 1;
            end else begin
                out_ready <= 1'b1;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_errors();
        send_raw(1);
        send_raw(10);
        send_frame(3, 0, 1);
        send_frame(3, 1, 0);
        send_frame(MAX_PL + 1, 1, 1);
        send_raw(140);
    endtask

    task automatic test_sizes();
        send_frame(1, 1, 1);
        send_frame(16, 1, 1);
        send_byte(8'hFF, 0); send_byte(8'h00, 1);
    endtask

    task automatic test_limits();
        logic [63:0] kl;
        int lims [4] = '{1, 0, 31, 7};
        foreach (lims[j]) begin
            wait_drained();
            kl = {$urandom, $urandom};
            reg_write(ADDR_KEY_LO, kl);
            reg_write(ADDR_KEY_HI, {$urandom, $urandom});
            reg_write(ADDR_LIMIT, 64'(lims[j]));
            send_frame(1, 1, 1);
            send_frame(8, 1, 1);
        end
        wait_drained();
        reg_write(ADDR_KEY_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(ADDR_KEY_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(ADDR_LIMIT, 64'd16);
        send_frame(16, 1, 1);
    endtask

    task automatic test_random();
        int sent, pick;
        sent = 0;
        while (sent < 100) begin
            pick = $urandom_range(0, 9);
            if (sent % 120 == 119) begin
                wait_drained();
                reg_write(ADDR_KEY_LO, {$urandom, $urandom});
                reg_write(ADDR_KEY_HI, {$urandom, $urandom});
                reg_write(ADDR_LIMIT, 64'($urandom_range(4, 16)));
            end
            if (pick < 7) begin
                pick = $urandom_range(1, 16);
                send_frame(pick, 1, 1);
                sent += 10 + pick;
            end else if (pick == 7) begin
                send_frame($urandom_range(1, 17), $urandom_range(0, 1), 0);
                sent += 12;
            end else begin
                pick = $urandom_range(1, 12);
                send_raw(pick);
                sent += pick;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        test_errors();
        test_sizes();
        test_limits();
        test_random();
        wait_drained();
        if (mismatches == 0 && expected_beats.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/aad_pkg.sv
sv/aad_aes_round.sv
sv/advert_aes_ctr_decrypt.sv
sim/tb_advert_aes_ctr_decrypt.sv
